// ===== design/bpa_pkg.sv =====
// bpa_pkg: shared types and constants of the buddy page allocator
// used by buddy_page_allocator; depends on nothing
`default_nettype none
package bpa_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // free tag values
  localparam logic TAG_USED = 1'b0;
  localparam logic TAG_FREE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_NUM_ORDERS = 2'd0;
  localparam logic [1:0] REG_FIRST_PAGE = 2'd1;
  localparam logic [1:0] REG_END_PAGE   = 2'd2;

  // reset values of the registers
  localparam logic [3:0]  NUM_ORDERS_RST = 4'd13;
  localparam logic [11:0] FIRST_PAGE_RST = 12'd0;
  localparam logic [12:0] END_PAGE_RST   = 13'd4096;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_SCAN,
    ST_A_UNLINK,
    ST_A_SPLIT,
    ST_F_CHECK,
    ST_F_META,
    ST_F_MCHECK,
    ST_F_MREAD,
    ST_F_PUSH,
    ST_F_PUSH2
  } state_t;

endpackage
`default_nettype wire

// ===== design/bpa_ram.sv =====
// bpa_ram: generic single-write, single-read memory with registered read
// depends on nothing
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/buddy_page_allocator.sv =====
// buddy_page_allocator: buddy allocator sequencer over per-page memories
// depends on bpa_pkg and bpa_ram
//
// usage:
//   command channel: drive cmd, req_order and page_index with start high;
//   the beat is taken at an edge where busy is low. busy stays high until
//   the result is produced.
//   result channel: done is high for one cycle with block_page and ok; the
//   receiver cannot stall, so the beat is taken in that cycle.
//   config: APB-style port, num_orders at 0x0, first_page at 0x4, end_page
//   at 0x8; write only while idle.
// sequence:
//   alloc: checks the list heads from req_order upward, unlinks the first
//   free block found, then splits it level by level, each split writing
//   the link and order memories once when the buddy lies below PAGES;
//   a failed alloc has no split levels.
//   free: checks the index, then the tag and alignment, where a rejected
//   free ends; each merge level reads the buddy from memory and unlinks it
//   if it matches; then the block is pushed onto its free list. the next
//   beat can be taken in the cycle done is high.
// reset: a clearing pass writes the order/tag memory, one page a cycle;
//   busy is high meanwhile, config writes still work.
`default_nettype none
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGES  = 4096,
  parameter int ORDERS = 13
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd,
  input  wire logic [3:0]  req_order,
  input  wire logic [11:0] page_index,
  // result
  output logic             done,
  output logic [11:0]      block_page,
  output logic             ok,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PW  = $clog2(PAGES);
  localparam int LW  = $clog2(PAGES + ORDERS);
  localparam int OW  = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int EW  = $clog2(ORDERS + 1);
  localparam int JW  = (EW > 4) ? EW : 4;
  localparam int AW0 = (PW > ORDERS) ? PW : ORDERS;
  localparam int AW  = ((AW0 > 13) ? AW0 : 13) + 1;
  localparam int MW  = OW + 1;

  localparam logic [LW-1:0] HEAD_BASE = LW'(PAGES);
  localparam logic [AW-1:0] PAGES_A   = AW'(PAGES);

  state_t state, state_next;

  logic [3:0]    num_orders;
  logic [11:0]   first_page;
  logic [12:0]   end_page;
  logic [PW-1:0] cnt;
  logic [JW-1:0] jj;
  logic [3:0]    req_r;
  logic [11:0]   pidx;
  logic [PW-1:0] bb;
  logic [PW-1:0] bud;
  logic [OW-1:0] ord;
  logic [LW-1:0] head_next [ORDERS];

  // memory ports
  logic          meta_we;
  logic [PW-1:0] meta_wa, meta_ra;
  logic [MW-1:0] meta_wd, meta_rd;
  logic          nx_we, pv_we;
  logic [PW-1:0] nx_wa, pv_wa, lk_ra;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

  // head write and result
  logic          hd_we;
  logic [OW-1:0] hd_idx;
  logic [LW-1:0] hd_val;
  logic          fin, fin_ok;
  logic [11:0]   fin_page;

  // derived values
  logic [JW-1:0] eo;
  logic [LW-1:0] hn;
  logic          hn_page;
  logic [JW-1:0] jm;
  logic [AW-1:0] bud_s;
  logic          bud_s_ok;
  logic [AW-1:0] idx_a;
  logic          idx_ok;
  logic          tag_rd;
  logic [OW-1:0] ord_rd, ordc;
  logic          misalign;
  logic [AW-1:0] bud_m;
  logic          can_merge;
  logic          buddy_match;
  logic          p_page, p_head, n_page;
  logic [LW-1:0] p_off;
  logic [LW-1:0] nn;
  logic          nn_page;

  bpa_ram #(.WIDTH(MW), .DEPTH(PAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .raddr(meta_ra), .rdata(meta_rd)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .raddr(lk_ra), .rdata(nx_rd)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .raddr(lk_ra), .rdata(pv_rd)
  );

  // effective order count, saturated to 1..ORDERS
  always_comb begin
    if (num_orders == 4'd0) begin
      eo = JW'(1);
    end else if (JW'(num_orders) > JW'(ORDERS)) begin
      eo = JW'(ORDERS);
    end else begin
      eo = JW'(num_orders);
    end
  end

  // alloc helpers
  assign hn       = head_next[jj[OW-1:0]];
  assign hn_page  = hn < HEAD_BASE;
  assign jm       = jj - JW'(1);
  assign bud_s    = AW'(bb) + (AW'(1) << jm);
  assign bud_s_ok = bud_s < PAGES_A;

  // free helpers
  assign idx_a  = AW'(pidx);
  assign idx_ok = (idx_a >= AW'(first_page)) && (idx_a < AW'(end_page)) &&
                  (idx_a < PAGES_A);
  assign tag_rd = meta_rd[0];
  assign ord_rd = meta_rd[MW-1:1];
  assign ordc   = (JW'(ord_rd) >= eo) ? OW'(eo - JW'(1)) : ord_rd;
  assign misalign = (AW'(bb) & ((AW'(1) << ordc) - AW'(1))) != AW'(0);
  assign bud_m  = AW'(bb) ^ (AW'(1) << ord);
  assign can_merge = (JW'(ord) + JW'(1) < eo) && (bud_m >= AW'(first_page)) &&
                     (bud_m < AW'(end_page)) && (bud_m < PAGES_A);
  assign buddy_match = (tag_rd == TAG_FREE) && (ord_rd == ord);

  // unlink decode of the links just read
  assign p_off  = pv_rd - HEAD_BASE;
  assign p_page = pv_rd < HEAD_BASE;
  assign n_page = nx_rd < HEAD_BASE;
  assign p_head = !p_page && (p_off < LW'(ORDERS));

  // push helpers
  assign nn      = head_next[ord];
  assign nn_page = nn < HEAD_BASE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == PW'(PAGES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = (cmd == CMD_FREE) ? ST_F_CHECK : ST_A_SCAN;
      end
      ST_A_SCAN: begin
        if (jj >= eo) state_next = ST_IDLE;
        else if (hn_page) state_next = ST_A_UNLINK;
      end
      ST_A_UNLINK: begin
        state_next = (jj > JW'(req_r)) ? ST_A_SPLIT : ST_IDLE;
      end
      ST_A_SPLIT: begin
        if (jm == JW'(req_r)) state_next = ST_IDLE;
      end
      ST_F_CHECK: begin
        state_next = idx_ok ? ST_F_META : ST_IDLE;
      end
      ST_F_META: begin
        state_next = (tag_rd != TAG_USED || misalign) ? ST_IDLE : ST_F_MCHECK;
      end
      ST_F_MCHECK: begin
        state_next = can_merge ? ST_F_MREAD : ST_F_PUSH;
      end
      ST_F_MREAD: begin
        state_next = buddy_match ? ST_F_MCHECK : ST_F_PUSH;
      end
      ST_F_PUSH: begin
        state_next = ST_F_PUSH2;
      end
      ST_F_PUSH2: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory strobes, head writes and result
  always_comb begin
    meta_we  = 1'b0;
    meta_wa  = bb;
    meta_wd  = {ord, TAG_FREE};
    meta_ra  = bb;
    lk_ra    = bud;
    nx_we    = 1'b0;
    nx_wa    = pv_rd[PW-1:0];
    nx_wd    = nx_rd;
    pv_we    = 1'b0;
    pv_wa    = nx_rd[PW-1:0];
    pv_wd    = pv_rd;
    hd_we    = 1'b0;
    hd_idx   = p_off[OW-1:0];
    hd_val   = nx_rd;
    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_page = pidx;
    case (state)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = cnt;
        meta_wd = '0;
      end
      ST_A_SCAN: begin
        lk_ra = hn[PW-1:0];
        if (jj >= eo) begin
          fin      = 1'b1;
          fin_page = '0;
        end
      end
      ST_A_UNLINK: begin
        nx_we   = p_page;
        pv_we   = n_page;
        hd_we   = p_head;
        meta_we = 1'b1;
        meta_wd = {OW'(req_r), TAG_USED};
        if (jj <= JW'(req_r)) begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_page = 12'(AW'(bb));
        end
      end
      ST_A_SPLIT: begin
        nx_we   = bud_s_ok;
        nx_wa   = bud_s[PW-1:0];
        nx_wd   = HEAD_BASE + LW'(jm);
        pv_we   = bud_s_ok;
        pv_wa   = bud_s[PW-1:0];
        pv_wd   = HEAD_BASE + LW'(jm);
        meta_we = bud_s_ok;
        meta_wa = bud_s[PW-1:0];
        meta_wd = {OW'(jm), TAG_FREE};
        hd_we   = bud_s_ok;
        hd_idx  = OW'(jm);
        hd_val  = LW'(bud_s);
        if (jm == JW'(req_r)) begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_page = 12'(AW'(bb));
        end
      end
      ST_F_CHECK: begin
        meta_ra = PW'(pidx);
        fin     = !idx_ok;
      end
      ST_F_META: begin
        fin = (tag_rd != TAG_USED) || misalign;
      end
      ST_F_MCHECK: begin
        meta_ra = bud_m[PW-1:0];
        lk_ra   = bud_m[PW-1:0];
      end
      ST_F_MREAD: begin
        nx_we = buddy_match && p_page;
        pv_we = buddy_match && n_page;
        hd_we = buddy_match && p_head;
      end
      ST_F_PUSH: begin
        meta_we = 1'b1;
        nx_we   = 1'b1;
        nx_wa   = bb;
        nx_wd   = nn;
        pv_we   = nn_page;
        pv_wa   = nn[PW-1:0];
        pv_wd   = LW'(bb);
      end
      ST_F_PUSH2: begin
        pv_we  = 1'b1;
        pv_wa  = bb;
        pv_wd  = HEAD_BASE + LW'(ord);
        hd_we  = 1'b1;
        hd_idx = ord;
        hd_val = LW'(bb);
        fin    = 1'b1;
        fin_ok = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
      for (int k = 0; k < ORDERS; k++) begin
        head_next[k] <= HEAD_BASE + LW'(k);
      end
    end else begin
      state <= state_next;
      done  <= fin;
      if (hd_we) head_next[hd_idx] <= hd_val;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + PW'(1);
        end
        ST_IDLE: begin
          jj    <= JW'(req_order);
          req_r <= req_order;
          pidx  <= page_index;
        end
        ST_A_SCAN: begin
          if (hn_page) bb <= hn[PW-1:0];
          else jj <= jj + JW'(1);
        end
        ST_A_SPLIT: begin
          jj <= jm;
        end
        ST_F_CHECK: begin
          bb <= PW'(pidx);
        end
        ST_F_META: begin
          ord <= ordc;
        end
        ST_F_MCHECK: begin
          bud <= bud_m[PW-1:0];
        end
        ST_F_MREAD: begin
          if (buddy_match) begin
            ord <= ord + OW'(1);
            if (bud < bb) bb <= bud;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (fin) begin
      block_page <= fin_page;
      ok         <= fin_ok;
    end
  end

  assign busy = (state != ST_IDLE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_orders <= NUM_ORDERS_RST;
      first_page <= FIRST_PAGE_RST;
      end_page   <= END_PAGE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NUM_ORDERS: num_orders <= pwdata[3:0];
        REG_FIRST_PAGE: first_page <= pwdata[11:0];
        REG_END_PAGE:   end_page   <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // config read back
  always_comb begin
    case (paddr[3:2])
      REG_NUM_ORDERS: prdata = 32'(num_orders);
      REG_FIRST_PAGE: prdata = 32'(first_page);
      REG_END_PAGE:   prdata = 32'(end_page);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule
`default_nettype wire

// ===== design/bpa_chk.sv =====
// bpa_chk: port-level checker of buddy_page_allocator, bound to the top
// depends on buddy_page_allocator ports
`default_nettype none
module bpa_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // a taken command beat makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command beat taken but block not busy");

  // a result only follows busy cycles
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without work");

  // idle and no result means no result next
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy && !done && !start |=> !done)
    else $error("result beat invented while idle");

  // reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("no clearing pass after reset");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
`default_nettype wire
